// File: design/ssfl_pkg.sv
// Shared types and constants for the streaming first/last substring search.
// Holds the beat structs, the configuration register set and register indexes.
// No dependencies.
package ssfl_pkg;

  localparam int POS_W       = 16;
  localparam int PAT_W       = 64;
  localparam int LEN_REG_W   = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int DEF_MAX_PAT = 8;
  localparam int DEF_MAX_TXT = 65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES  = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1,
    CFG_SEARCH_LAST    = 2'd2,
    CFG_POSITION_BOUND = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_position;
    logic             too_long;
  } out_beat_t;

  typedef struct packed {
    logic [PAT_W-1:0]     pattern_bytes;
    logic [LEN_REG_W-1:0] pattern_length;
    logic                 search_last;
    logic [POS_W-1:0]     position_bound;
  } cfg_t;

endpackage

// File: design/ssfl_cfg.sv
// Configuration register file for the substring search.
// Decodes the plain write port and derives the clamped pattern length.
// Depends on ssfl_pkg.
module ssfl_cfg
  import ssfl_pkg::*;
#(
  parameter int MAX_PATTERN = DEF_MAX_PAT,
  parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [PAT_W-1:0]      cfg_wdata,
  output cfg_t                  cfg,
  output logic [LEN_W-1:0]      eff_len
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wen) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_PATTERN_BYTES:  cfg_nxt.pattern_bytes  = cfg_wdata;
        CFG_PATTERN_LENGTH: cfg_nxt.pattern_length = cfg_wdata[LEN_REG_W-1:0];
        CFG_SEARCH_LAST:    cfg_nxt.search_last    = cfg_wdata[0];
        CFG_POSITION_BOUND: cfg_nxt.position_bound = cfg_wdata[POS_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_bytes  <= '0;
      cfg_r.pattern_length <= LEN_REG_W'(1);
      cfg_r.search_last    <= 1'b0;
      cfg_r.position_bound <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // clamp length to 1..MAX_PATTERN
  always_comb begin
    if (cfg_r.pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (cfg_r.pattern_length > LEN_REG_W'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = LEN_W'(cfg_r.pattern_length);
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/ssfl_cmp.sv
// Parallel window compare: one comparator row per possible pattern length.
// The row matching the configured length selects the hit.
// Depends on ssfl_pkg.
module ssfl_cmp
  import ssfl_pkg::*;
#(
  parameter int MAX_PATTERN = DEF_MAX_PAT,
  parameter int LEN_W       = $clog2(MAX_PATTERN + 1),
  parameter int WIN_W       = MAX_PATTERN * 8
) (
  input  logic [WIN_W-1:0] window,
  input  logic [PAT_W-1:0] pattern,
  input  logic [LEN_W-1:0] len,
  output logic             hit
);

  logic [MAX_PATTERN-1:0] row_hit;
  logic [MAX_PATTERN-1:0] row_sel;

  // row r checks length r+1: pattern byte k against window lane r-k
  for (genvar r = 0; r < MAX_PATTERN; r++) begin : g_row
    logic [MAX_PATTERN-1:0] eq;
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_lane
      if (k <= r) begin : g_used
        assign eq[k] = (pattern[8*k +: 8] == window[8*(r-k) +: 8]);
      end else begin : g_unused
        assign eq[k] = 1'b1;
      end
    end
    assign row_hit[r] = &eq;
    assign row_sel[r] = (len == LEN_W'(r + 1));
  end

  assign hit = |(row_hit & row_sel);

endmodule

// File: design/substring_first_last_search.sv
// Streaming first/last substring search, top level.
// Instantiates ssfl_cfg and ssfl_cmp; depends on ssfl_pkg.
//
// Usage:
//   Text bytes arrive on the in_ channel (valid/stall), one per beat, with
//   final_byte set on the last byte of a text. A pattern of 1..MAX_PATTERN bytes,
//   its length, the search mode and the position bound are set through the cfg_
//   write port while the block is idle.
//   Each accepted byte lands in an input register; the window compare then runs
//   on it, and the search state updates as it leaves that register. A final byte
//   loads one result beat (found, match_position, too_long) into the output
//   register as it leaves the input register, and clears the search state.
//   Bytes enter at one per cycle while in_stall is low (combinational compare).
//   When out_stall holds a waiting result, ordinary bytes still flow; a new
//   final byte waits in the input register and in_stall rises until the
//   output register frees.
//   Reset (rst_n low, synchronous) clears all search state, empties both
//   registers and returns the configuration to its defaults (length 1).
module substring_first_last_search
  import ssfl_pkg::*;
#(
  parameter int MAX_PATTERN = DEF_MAX_PAT,
  parameter int MAX_TEXT    = DEF_MAX_TXT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_beat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_beat,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAT_W-1:0]     cfg_wdata
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int WIN_W = MAX_PATTERN * 8;
  localparam int REC_W = (MAX_PATTERN > 1) ? (MAX_PATTERN - 1) * 8 : 8;
  localparam int CNT_W = $clog2(MAX_TEXT) + 1;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W + 1;

  cfg_t             cfg;
  logic [LEN_W-1:0] eff_len;
  logic             hit;

  logic             s1_valid_r, s1_valid_nxt;
  in_beat_t         s1_beat_r;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_beat_r, out_beat_nxt;

  logic [REC_W-1:0] recent_r, recent_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [POS_W-1:0] best_r, best_nxt;
  logic             have_r, have_nxt;
  logic             ovf_r, ovf_nxt;

  logic [REC_W+7:0] win_full;
  logic [WIN_W-1:0] window;
  logic             out_free, s1_go, fire, in_take;
  logic             past_end, reach, take;
  logic [CNT_W-1:0] idx_inc, len_ext, start;
  logic [CMP_W-1:0] start_c, bound_c;

  ssfl_cfg #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LEN_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .eff_len   (eff_len)
  );

  assign win_full = {recent_r, s1_beat_r.text_byte};
  assign window   = win_full[WIN_W-1:0];

  ssfl_cmp #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LEN_W),
    .WIN_W       (WIN_W)
  ) u_cmp (
    .window  (window),
    .pattern (cfg.pattern_bytes),
    .len     (eff_len),
    .hit     (hit)
  );

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = !s1_beat_r.final_byte || out_free;
  assign fire     = s1_valid_r && s1_go;
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  // match position arithmetic
  assign past_end = (count_r >= CNT_W'(MAX_TEXT));
  assign idx_inc  = count_r + CNT_W'(1);
  assign len_ext  = CNT_W'(eff_len);
  assign reach    = (idx_inc >= len_ext);
  assign start    = idx_inc - len_ext;
  assign start_c  = CMP_W'(start);
  assign bound_c  = CMP_W'(cfg.position_bound);

  always_comb begin
    if (cfg.search_last) begin
      take = reach && hit && (start_c <= bound_c);
    end else begin
      take = reach && hit && !have_r && (start_c >= bound_c);
    end
  end

  always_comb begin
    recent_nxt    = recent_r;
    count_nxt     = count_r;
    best_nxt      = best_r;
    have_nxt      = have_r;
    ovf_nxt       = ovf_r;
    out_beat_nxt  = out_beat_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (fire) begin
      recent_nxt = win_full[REC_W-1:0];
      if (past_end) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = idx_inc;
        if (take) begin
          best_nxt = POS_W'(start);
          have_nxt = 1'b1;
        end
      end
      if (s1_beat_r.final_byte) begin
        out_valid_nxt               = 1'b1;
        out_beat_nxt.found          = have_nxt;
        out_beat_nxt.match_position = have_nxt ? best_nxt : '0;
        out_beat_nxt.too_long       = ovf_nxt;
        // drop search state for the next text
        recent_nxt = '0;
        count_nxt  = '0;
        best_nxt   = '0;
        have_nxt   = 1'b0;
        ovf_nxt    = 1'b0;
      end
    end
  end

  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      recent_r    <= '0;
      count_r     <= '0;
      best_r      <= '0;
      have_r      <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      recent_r    <= recent_nxt;
      count_r     <= count_nxt;
      best_r      <= best_nxt;
      have_r      <= have_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_beat_r <= in_beat;
    end
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  a_no_pos_without_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_beat_r.found |-> out_beat_r.match_position == '0)
    else $error("match_position nonzero on a not-found result");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_beat_r.final_byte |=> count_r == '0 && !have_r && !ovf_r)
    else $error("search state not cleared after a final byte");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TEXT))
    else $error("byte count past text limit");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_beat_r.final_byte && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

  a_final_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_beat_r.final_byte |=> out_valid_r)
    else $error("final byte produced no result");

endmodule
